### src/dpe_pkg.sv
// Package for the register-mapped DMA / PRBS engine.
// Holds opcodes, result kinds, register map, controller states and the
// command/status structs shared by the controller, datapath and top level.
package dpe_pkg;

    localparam int MEMORY_WORDS_DEFAULT = 256;

    // opcodes (s_tuser)
    localparam logic [1:0] OP_BUS_READ  = 2'd0;
    localparam logic [1:0] OP_BUS_WRITE = 2'd1;
    localparam logic [1:0] OP_DMA_RDATA = 2'd2;
    localparam logic [1:0] OP_DMA_WACK  = 2'd3;

    // result kinds (m_tuser)
    localparam logic [2:0] KIND_READ     = 3'd0;
    localparam logic [2:0] KIND_WACK     = 3'd1;
    localparam logic [2:0] KIND_DMA_RD   = 3'd2;
    localparam logic [2:0] KIND_DMA_WR   = 3'd3;
    localparam logic [2:0] KIND_IGNORED  = 3'd4;

    // register map
    localparam logic [31:0] REG_SRC    = 32'h00;
    localparam logic [31:0] REG_DST    = 32'h04;
    localparam logic [31:0] REG_LEN    = 32'h08;
    localparam logic [31:0] REG_CTRL   = 32'h0c;
    localparam logic [31:0] REG_STAT   = 32'h10;
    localparam logic [31:0] REG_SEED   = 32'h14;
    localparam logic [31:0] ALIAS_LOW  = 32'h100;
    localparam logic [31:0] ALIAS_HIGH = 32'h120;
    localparam logic [31:0] MEM_BASE   = 32'h1000;

    localparam int CTRL_BIT_GO   = 0;
    localparam int CTRL_DIR      = 1;
    localparam int CTRL_BIT_FILL = 2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_FILL,
        ST_ACK,
        ST_ACK_MORE,
        ST_REQ,
        ST_REQ_OUT,
        ST_IGN
    } state_t;

    typedef enum logic [2:0] {
        OUT_READ,
        OUT_ACK,
        OUT_ACK_MORE,
        OUT_REQ,
        OUT_IGN
    } out_sel_t;

    typedef struct packed {
        logic     latch_in;
        logic     bus_write;
        logic     start_prbs;
        logic     start_reject;
        logic     start_dma;
        logic     dma_resp;
        logic     adv_fin;
        logic     adv_inc;
        logic     sweep_step;
        logic     sweep_zero;
        logic     mem_rd_bus;
        logic     mem_rd_req;
        logic     load_out;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       start_req;
        logic       prbs_sel;
        logic       start_ok;
        logic       dma_match;
        logic       adv_last;
        logic       sweep_last;
        logic       out_free;
    } status_t;

    function automatic logic [31:0] map_alias(input logic [31:0] a);
        if (a >= ALIAS_LOW && a < ALIAS_HIGH)
            return a - ALIAS_LOW;
        return a;
    endfunction

    function automatic logic [31:0] xorshift_step(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

endpackage

### src/dpe_ctrl.sv
// Controller state machine of the DMA / PRBS engine.
// Depends on dpe_pkg; drives the datapath through cmd_t, watches status_t.
module dpe_ctrl
    import dpe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    input  status_t stat,
    output logic    s_tready,
    output cmd_t    cmd
);

    state_t fsm_reg, fsm_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fsm_reg <= ST_CLEAR;
        else
            fsm_reg <= fsm_next;
    end

    always_comb
    begin
        fsm_next    = fsm_reg;
        cmd         = '0;
        cmd.out_sel = OUT_IGN;
        s_tready    = 1'b0;
        case (fsm_reg)
            ST_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
                cmd.sweep_zero = 1'b1;
                if (stat.sweep_last)
                    fsm_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch_in = 1'b1;
                    fsm_next     = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.op)
                    OP_BUS_READ:
                    begin
                        cmd.mem_rd_bus = 1'b1;
                        fsm_next       = ST_READ;
                    end
                    OP_BUS_WRITE:
                    begin
                        if (stat.start_req)
                        begin
                            if (stat.prbs_sel)
                            begin
                                cmd.start_prbs = 1'b1;
                                fsm_next       = ST_FILL;
                            end
                            else if (stat.start_ok)
                            begin
                                cmd.start_dma = 1'b1;
                                fsm_next      = ST_ACK_MORE;
                            end
                            else
                            begin
                                cmd.start_reject = 1'b1;
                                fsm_next         = ST_ACK;
                            end
                        end
                        else
                        begin
                            cmd.bus_write = 1'b1;
                            fsm_next      = ST_ACK;
                        end
                    end
                    default:
                    begin
                        if (stat.dma_match)
                        begin
                            cmd.dma_resp = 1'b1;
                            if (stat.adv_last)
                            begin
                                // final response: no result
                                cmd.adv_fin = 1'b1;
                                fsm_next    = ST_IDLE;
                            end
                            else
                            begin
                                cmd.adv_inc = 1'b1;
                                fsm_next    = ST_REQ;
                            end
                        end
                        else
                            fsm_next = ST_IGN;
                    end
                endcase
            end
            ST_FILL:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                    fsm_next = ST_ACK;
            end
            ST_READ:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = OUT_READ;
                    fsm_next     = ST_IDLE;
                end
            end
            ST_ACK:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = OUT_ACK;
                    fsm_next     = ST_IDLE;
                end
            end
            ST_ACK_MORE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = OUT_ACK_MORE;
                    fsm_next     = ST_REQ;
                end
            end
            ST_REQ:
            begin
                // fetch local word for a write request
                cmd.mem_rd_req = 1'b1;
                fsm_next       = ST_REQ_OUT;
            end
            ST_REQ_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = OUT_REQ;
                    fsm_next     = ST_IDLE;
                end
            end
            ST_IGN:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = OUT_IGN;
                    fsm_next     = ST_IDLE;
                end
            end
            default:
                fsm_next = ST_IDLE;
        endcase
    end

endmodule

### src/dpe_datapath.sv
// Datapath of the DMA / PRBS engine: input latch, register file, word
// memory, sweep counter and output register. Depends on dpe_pkg.
module dpe_datapath
    import dpe_pkg::*;
#(
    parameter int MEMORY_WORDS = MEMORY_WORDS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [95:0] s_tdata,   // bus_address, write_word, response_word
    input  logic [1:0]  s_tuser,   // opcode
    input  logic        m_tready,
    input  cmd_t        cmd,
    output status_t     stat,
    output logic        m_tvalid,
    output logic [95:0] m_tdata,   // read_word, dma_address, dma_write_word
    output logic [2:0]  m_tuser,   // result_kind
    output logic        m_tlast
);

    localparam int IDX_W = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
    localparam logic [32:0] WIN_END = 33'(MEM_BASE) + 33'(MEMORY_WORDS) * 33'd4;
    localparam logic [32:0] MW33 = 33'(MEMORY_WORDS);

    // latched transaction
    logic [1:0]  in_op_reg;
    logic [31:0] in_addr_reg, in_wdata_reg, in_resp_reg;

    logic [31:0] src_reg, dst_reg, len_reg, ti_reg, seed_reg, fill_base_reg;
    logic        active_reg, finished_reg, err_reg, to_ext_reg;
    logic [IDX_W-1:0] sweep_idx_reg;

    logic [31:0] mem [MEMORY_WORDS];
    logic [31:0] rdata_reg;

    logic        m_tvalid_reg, last_reg;
    logic [2:0]  kind_reg;
    logic [31:0] rword_reg, daddr_reg, dwword_reg;

    logic        last_next;
    logic [2:0]  kind_next;
    logic [31:0] rword_next, daddr_next, dwword_next;

    logic [31:0] a, win_off, reg_val, li_src, li_dst, nx, base;
    logic        in_win, li_src_ok, li_dst_ok;
    logic [IDX_W-1:0] bus_idx, raddr, waddr;
    logic        we;
    logic [31:0] wdata;
    logic [32:0] win_sum;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            in_op_reg    <= s_tuser;
            in_addr_reg  <= s_tdata[31:0];
            in_wdata_reg <= s_tdata[63:32];
            in_resp_reg  <= s_tdata[95:64];
        end
    end

    always_comb
    begin
        a         = map_alias(in_addr_reg);
        in_win    = (a >= MEM_BASE) && ({1'b0, a} < WIN_END);
        win_off   = a - MEM_BASE;
        bus_idx   = win_off[IDX_W+1:2];
        li_src    = src_reg + ti_reg;
        li_dst    = dst_reg + ti_reg;
        li_src_ok = li_src < 32'(MEMORY_WORDS);
        li_dst_ok = li_dst < 32'(MEMORY_WORDS);
        nx        = xorshift_step(seed_reg);
        base      = in_wdata_reg[CTRL_DIR] ? src_reg : dst_reg;
        win_sum   = {1'b0, base} + {1'b0, len_reg};
        case (a)
            REG_SRC:  reg_val = src_reg;
            REG_DST:  reg_val = dst_reg;
            REG_LEN:  reg_val = len_reg;
            REG_CTRL: reg_val = {30'd0, to_ext_reg, 1'b0};
            REG_STAT: reg_val = {29'd0, err_reg, finished_reg, active_reg};
            REG_SEED: reg_val = seed_reg;
            default:  reg_val = 32'd0;
        endcase
    end

    always_comb
    begin
        stat.op         = in_op_reg;
        stat.start_req  = (a == REG_CTRL) && in_wdata_reg[CTRL_BIT_GO] && !active_reg;
        stat.prbs_sel   = in_wdata_reg[CTRL_BIT_FILL];
        stat.start_ok   = (len_reg != 32'd0) && ({1'b0, len_reg} <= MW33) && (win_sum <= MW33);
        stat.dma_match  = active_reg && (((in_op_reg == OP_DMA_RDATA) && !to_ext_reg) ||
                                         ((in_op_reg == OP_DMA_WACK) && to_ext_reg));
        stat.adv_last   = ({1'b0, ti_reg} + 33'd1) >= {1'b0, len_reg};
        stat.sweep_last = sweep_idx_reg == IDX_W'(MEMORY_WORDS - 1);
        stat.out_free   = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg      <= '0;
            dst_reg      <= '0;
            len_reg      <= '0;
            ti_reg       <= '0;
            seed_reg     <= 32'd1;
            active_reg   <= 1'b0;
            finished_reg <= 1'b0;
            err_reg      <= 1'b0;
            to_ext_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.bus_write)
            begin
                case (a)
                    REG_SRC:  src_reg  <= in_wdata_reg;
                    REG_DST:  dst_reg  <= in_wdata_reg;
                    REG_LEN:  len_reg  <= in_wdata_reg;
                    REG_SEED: seed_reg <= (in_wdata_reg == 32'd0) ? 32'd1 : in_wdata_reg;
                    default:  ;
                endcase
            end
            if (cmd.start_prbs)
            begin
                seed_reg     <= nx;
                finished_reg <= 1'b1;
                err_reg      <= 1'b0;
                ti_reg       <= '0;
            end
            if (cmd.start_reject)
            begin
                finished_reg <= 1'b1;
                err_reg      <= 1'b1;
                ti_reg       <= '0;
            end
            if (cmd.start_dma)
            begin
                to_ext_reg   <= in_wdata_reg[CTRL_DIR];
                active_reg   <= 1'b1;
                finished_reg <= 1'b0;
                err_reg      <= 1'b0;
                ti_reg       <= '0;
            end
            if (cmd.adv_fin)
            begin
                active_reg   <= 1'b0;
                finished_reg <= 1'b1;
            end
            if (cmd.adv_inc)
                ti_reg <= ti_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sweep_idx_reg <= '0;
        else if (cmd.sweep_step)
            sweep_idx_reg <= stat.sweep_last ? '0 : sweep_idx_reg + IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_prbs)
            fill_base_reg <= nx;
    end

    // one write port: sweep, bus write or returned DMA word
    always_comb
    begin
        we    = 1'b0;
        waddr = sweep_idx_reg;
        wdata = cmd.sweep_zero ? 32'd0 : fill_base_reg + 32'(sweep_idx_reg);
        if (cmd.sweep_step)
            we = 1'b1;
        else if (cmd.bus_write && in_win)
        begin
            we    = 1'b1;
            waddr = bus_idx;
            wdata = in_wdata_reg;
        end
        else if (cmd.dma_resp && (in_op_reg == OP_DMA_RDATA) && li_dst_ok)
        begin
            we    = 1'b1;
            waddr = li_dst[IDX_W-1:0];
            wdata = in_resp_reg;
        end
        raddr = cmd.mem_rd_req ? li_src[IDX_W-1:0] : bus_idx;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (cmd.mem_rd_bus || cmd.mem_rd_req)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.load_out)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_comb
    begin
        kind_next   = KIND_IGNORED;
        rword_next  = '0;
        daddr_next  = '0;
        dwword_next = '0;
        last_next   = 1'b1;
        case (cmd.out_sel)
            OUT_READ:
            begin
                kind_next  = KIND_READ;
                rword_next = in_win ? rdata_reg : reg_val;
            end
            OUT_ACK:
                kind_next = KIND_WACK;
            OUT_ACK_MORE:
            begin
                kind_next = KIND_WACK;
                last_next = 1'b0;
            end
            OUT_REQ:
            begin
                if (to_ext_reg)
                begin
                    kind_next   = KIND_DMA_WR;
                    daddr_next  = dst_reg + {ti_reg[29:0], 2'b00};
                    dwword_next = li_src_ok ? rdata_reg : 32'd0;
                end
                else
                begin
                    kind_next  = KIND_DMA_RD;
                    daddr_next = src_reg + {ti_reg[29:0], 2'b00};
                end
            end
            default:
                kind_next = KIND_IGNORED;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            kind_reg   <= kind_next;
            rword_reg  <= rword_next;
            daddr_reg  <= daddr_next;
            dwword_reg <= dwword_next;
            last_reg   <= last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {dwword_reg, daddr_reg, rword_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

### src/register_mapped_dma_prbs_engine_core.sv
// Register-mapped DMA / PRBS engine: one transaction in, none, one or two
// results out. A bus read or write and an ignored response pass through
// decode, memory read or register update and output load; a DMA response that
// issues the next request adds a local memory read before its output load, the
// final DMA response (no result) returns to idle after decode, and an accepted
// DMA start loads its ack, then the first request; a held-off m_tready stalls
// each output load. A PRBS start sweeps the whole memory, one word a cycle.
// After reset a clearing pass zeroes the memory while s_tready stays low.
// Results wait in an output register; the next transaction is accepted while
// one is still pending. Depends on dpe_pkg, dpe_ctrl and dpe_datapath.
module register_mapped_dma_prbs_engine_core
    import dpe_pkg::*;
#(
    parameter int MEMORY_WORDS = MEMORY_WORDS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // bus_address, write_word, response_word
    input  logic [1:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // read_word, dma_address, dma_write_word
    output logic [2:0]  m_tuser,   // result_kind
    output logic        m_tlast
);

    cmd_t    cmd;
    status_t stat;

    dpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    dpe_datapath #(
        .MEMORY_WORDS (MEMORY_WORDS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### tb/register_mapped_dma_prbs_engine_core_test.sv
// Self-checking testbench for register_mapped_dma_prbs_engine_core.
// Drives bus, DMA-response and noise transactions, predicts every result and
// checks it. Depends on dpe_pkg and the engine RTL only.
`timescale 1ns / 100ps

module register_mapped_dma_prbs_engine_core_test;
    import dpe_pkg::*;

    localparam int LOCAL_WORDS    = MEMORY_WORDS_DEFAULT;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;

    localparam logic [31:0] CTL_GO     = 32'h1 << CTRL_BIT_GO;
    localparam logic [31:0] CTL_TOEXT  = 32'h1 << CTRL_DIR;
    localparam logic [31:0] CTL_FILL   = 32'h1 << CTRL_BIT_FILL;
    localparam logic [31:0] STAT_BUSY  = 32'h1;
    localparam logic [31:0] STAT_DONE  = 32'h2;
    localparam logic [31:0] STAT_ERROR = 32'h4;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic [31:0] resp;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] rd;
        logic [31:0] addr;
        logic [31:0] wd;
        logic        is_last;
    } result_t;

    typedef struct packed {
        item_t   it;
        logic    pinned;
        result_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // bus_address, write_word, response_word
    logic [1:0]  s_tuser;   // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;   // read_word, dma_address, dma_write_word
    logic [2:0]  m_tuser;   // result_kind
    logic        m_tlast;

    register_mapped_dma_prbs_engine_core #(.MEMORY_WORDS(LOCAL_WORDS)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // engine state as predicted
    logic [31:0] src_reg, dst_reg, len_reg, word_idx, seed_reg;
    bit          busy, done_f, err_f, to_ext;
    logic [31:0] local_mem [LOCAL_WORDS];

    result_t     engine_replies [$];
    row_t        plan [$];

    bit          quiet;
    bit          hold_request;
    int unsigned mismatches, checked, sent, useful, directed_count;
    int unsigned dma_starts, fills, rejects, strays, holds, pauses;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] unalias(input logic [31:0] a);
        return (a >= ALIAS_LOW && a < ALIAS_HIGH) ? a - ALIAS_LOW : a;
    endfunction

    function automatic bit in_mem(input logic [31:0] a);
        return a >= MEM_BASE && {1'b0, a} < {1'b0, MEM_BASE} + 33'(4 * LOCAL_WORDS);
    endfunction

    function automatic logic [31:0] scramble(input logic [31:0] x);
        logic [31:0] t;
        t = x ^ (x << 13);
        t = t ^ (t >> 17);
        return t ^ (t << 5);
    endfunction

    function automatic logic [31:0] read_reg(input logic [31:0] a);
        logic [31:0] u;
        u = unalias(a);
        if (u == REG_SRC) return src_reg;
        if (u == REG_DST) return dst_reg;
        if (u == REG_LEN) return len_reg;
        if (u == REG_CTRL) return to_ext ? CTL_TOEXT : 32'h0;
        if (u == REG_STAT)
            return (busy ? STAT_BUSY : 32'h0) | (done_f ? STAT_DONE : 32'h0)
                 | (err_f ? STAT_ERROR : 32'h0);
        if (u == REG_SEED) return seed_reg;
        if (in_mem(u)) return local_mem[(u - MEM_BASE) >> 2];
        return 32'h0;
    endfunction

    function automatic result_t dma_request();
        result_t     r;
        logic [31:0] li;
        r = '0;
        r.is_last = 1'b1;
        if (to_ext)
        begin
            li = src_reg + word_idx;
            r.kind = KIND_DMA_WR;
            r.addr = dst_reg + (word_idx << 2);
            if (li < LOCAL_WORDS)
                r.wd = local_mem[li];
        end
        else
        begin
            r.kind = KIND_DMA_RD;
            r.addr = src_reg + (word_idx << 2);
        end
        return r;
    endfunction

    // Updates the predicted state for one accepted transaction; n results.
    task automatic predict_replies(input item_t it, output result_t r0, output result_t r1,
                                   output int n);
        logic [31:0] u, li;
        logic [32:0] base, span;
        bit          dir;
        r0 = '0;
        r1 = '0;
        r0.is_last = 1'b1;
        n = 1;
        if (it.op == OP_BUS_READ)
        begin
            r0.kind = KIND_READ;
            r0.rd = read_reg(it.addr);
        end
        else if (it.op == OP_BUS_WRITE)
        begin
            r0.kind = KIND_WACK;
            u = unalias(it.addr);
            if (u == REG_SRC) src_reg = it.wdata;
            else if (u == REG_DST) dst_reg = it.wdata;
            else if (u == REG_LEN) len_reg = it.wdata;
            else if (u == REG_SEED) seed_reg = (it.wdata == 32'h0) ? 32'h1 : it.wdata;
            else if (u == REG_CTRL)
            begin
                if (it.wdata[CTRL_BIT_GO] && !busy)
                begin
                    dir = it.wdata[CTRL_DIR];
                    done_f = 1'b0;
                    err_f = 1'b0;
                    word_idx = 32'h0;
                    base = {1'b0, dir ? src_reg : dst_reg};
                    span = {1'b0, len_reg};
                    if (it.wdata[CTRL_BIT_FILL])
                    begin
                        seed_reg = scramble(seed_reg);
                        for (int i = 0; i < LOCAL_WORDS; i++)
                            local_mem[i] = seed_reg + i;
                        done_f = 1'b1;
                        fills++;
                    end
                    else if (span == 0 || span > 33'(LOCAL_WORDS)
                             || base + span > 33'(LOCAL_WORDS))
                    begin
                        err_f = 1'b1;
                        done_f = 1'b1;
                        rejects++;
                    end
                    else
                    begin
                        to_ext = dir;
                        busy = 1'b1;
                        r0.is_last = 1'b0;
                        r1 = dma_request();
                        n = 2;
                        dma_starts++;
                    end
                end
            end
            else if (in_mem(u))
                local_mem[(u - MEM_BASE) >> 2] = it.wdata;
        end
        else if (busy && ((it.op == OP_DMA_WACK) == to_ext))
        begin
            if (!to_ext)
            begin
                li = dst_reg + word_idx;
                if (li < LOCAL_WORDS)
                    local_mem[li] = it.resp;
            end
            if ({1'b0, word_idx} + 33'd1 >= {1'b0, len_reg})
            begin
                // last word answered: no result
                busy = 1'b0;
                done_f = 1'b1;
                n = 0;
            end
            else
            begin
                word_idx++;
                r0 = dma_request();
            end
        end
        else
        begin
            r0.kind = KIND_IGNORED;
            strays++;
        end
    endtask

    function automatic item_t make_item(input logic [1:0] op, input logic [31:0] addr,
                                        input logic [31:0] wdata, input logic [31:0] resp);
        item_t it;
        it.op = op;
        it.addr = addr;
        it.wdata = wdata;
        it.resp = resp;
        return it;
    endfunction

    function automatic row_t fixed_row(input logic [1:0] op, input logic [31:0] addr,
                                       input logic [31:0] wdata, input logic [2:0] kind,
                                       input logic [31:0] rd);
        row_t r;
        r.it = make_item(op, addr, wdata, 32'h0);
        r.pinned = 1'b1;
        r.want = '0;
        r.want.kind = kind;
        r.want.rd = rd;
        r.want.is_last = 1'b1;
        return r;
    endfunction

    function automatic row_t model_row(input logic [1:0] op, input logic [31:0] addr,
                                       input logic [31:0] wdata, input logic [31:0] resp);
        row_t r;
        r.it = make_item(op, addr, wdata, resp);
        r.pinned = 1'b0;
        r.want = '0;
        return r;
    endfunction

    // Offers one transaction, waits for the handshake, records what it should cause.
    task automatic send(input item_t it, input bit pinned, input result_t want);
        result_t r0, r1;
        int      n;
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {it.resp, it.wdata, it.addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_replies(it, r0, r1, n);
        sent++;
        if (!(n == 1 && r0.kind == KIND_IGNORED))
            useful++;
        if (pinned)
            engine_replies.push_back(want);
        else
        begin
            if (n > 0) engine_replies.push_back(r0);
            if (n > 1) engine_replies.push_back(r1);
        end
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic bus_rd(input logic [31:0] a);
        send(make_item(OP_BUS_READ, a, $urandom, $urandom), 1'b0, '0);
    endtask

    task automatic bus_wr(input logic [31:0] a, input logic [31:0] d);
        send(make_item(OP_BUS_WRITE, a, d, $urandom), 1'b0, '0);
    endtask

    task automatic respond(input logic [1:0] op, input logic [31:0] w);
        send(make_item(op, $urandom, $urandom, w), 1'b0, '0);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (engine_replies.size() != 0)
            @(posedge clk);
        pauses++;
    endtask

    function automatic logic [31:0] reg_at(input logic [31:0] off);
        return ($urandom_range(0, 3) == 0) ? off + ALIAS_LOW : off;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, LOCAL_WORDS + 2);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_addr();
        logic [31:0] off;
        off = 4 * $urandom_range(0, 5);
        case ($urandom_range(0, 7))
            0, 1: return off;
            2: return off + ALIAS_LOW;
            3:
            begin
                // decode edges: alias limits, unaligned registers, window limits
                case ($urandom_range(0, 5))
                    0: return ALIAS_HIGH;
                    1: return ALIAS_HIGH - 1;
                    2: return ALIAS_LOW - 1;
                    3: return off + $urandom_range(1, 3);
                    4: return REG_SEED + 4;
                    default: return MEM_BASE - 1;
                endcase
            end
            4, 5: return MEM_BASE + 4 * $urandom_range(0, LOCAL_WORDS - 1);
            6: return MEM_BASE + $urandom_range(0, 4 * LOCAL_WORDS + 3);
            default: return $urandom;
        endcase
    endfunction

    // Ends any transfer still running, shortening it first if more than four words remain.
    task automatic finish_running();
        if (busy)
        begin
            if ({1'b0, len_reg} > {1'b0, word_idx} + 33'd4)
                bus_wr(reg_at(REG_LEN), 32'h1);
            while (busy)
                respond(to_ext ? OP_DMA_WACK : OP_DMA_RDATA, $urandom);
        end
    endtask

    task automatic run_transfer();
        logic [31:0] len, local_base;
        bit          dir;
        int          guard, pick;
        finish_running();
        dir = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 199) == 0)
            len = LOCAL_WORDS;
        else if ($urandom_range(0, 49) == 0)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(1, 8);
        local_base = $urandom_range(0, LOCAL_WORDS - len);
        bus_wr(reg_at(REG_SRC), dir ? local_base : $urandom);
        bus_wr(reg_at(REG_DST), dir ? $urandom : local_base);
        bus_wr(reg_at(REG_LEN), len);
        bus_wr(reg_at(REG_CTRL), ($urandom & ~CTL_FILL & ~CTL_TOEXT) | CTL_GO
                                 | (dir ? CTL_TOEXT : 32'h0));
        guard = 0;
        while (busy && guard < 300)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                bus_rd(pick_addr());
            else if (pick < 9)
                respond(to_ext ? OP_DMA_RDATA : OP_DMA_WACK, $urandom);
            else if (pick < 11)
                bus_wr(reg_at(REG_CTRL), $urandom | CTL_GO);
            else if (pick < 13)
                // retarget the local side mid-transfer, often out of range
                bus_wr(reg_at(to_ext ? REG_SRC : REG_DST),
                       $urandom_range(0, 1) ? $urandom : $urandom_range(0, LOCAL_WORDS + 4));
            else
                respond(to_ext ? OP_DMA_WACK : OP_DMA_RDATA, $urandom);
            guard++;
        end
        finish_running();
    endtask

    task automatic reject_start();
        logic [31:0] len, base;
        bit          dir;
        finish_running();
        dir = 1'($urandom_range(0, 1));
        len = $urandom_range(1, 8);
        base = 32'h0;
        case ($urandom_range(0, 3))
            0: len = 32'h0;
            1: len = $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                          : $urandom_range(LOCAL_WORDS + 1, 4096);
            2: base = $urandom_range(LOCAL_WORDS - len + 1, LOCAL_WORDS + 8);
            default: base = 32'hFFFF_FFFF - $urandom_range(0, 3);  // wraps in 32 bits
        endcase
        bus_wr(reg_at(dir ? REG_SRC : REG_DST), base);
        bus_wr(reg_at(REG_LEN), len);
        bus_wr(reg_at(REG_CTRL), ($urandom & ~CTL_FILL & ~CTL_TOEXT) | CTL_GO
                                 | (dir ? CTL_TOEXT : 32'h0));
        bus_rd(reg_at(REG_STAT));
    endtask

    task automatic run_fill();
        finish_running();
        if ($urandom_range(0, 1))
            bus_wr(reg_at(REG_SEED), ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom);
        bus_wr(reg_at(REG_CTRL), $urandom | CTL_GO | CTL_FILL);
        repeat ($urandom_range(2, 4))
            bus_rd(MEM_BASE + 4 * $urandom_range(0, LOCAL_WORDS - 1));
        bus_rd(reg_at(REG_SEED));
    endtask

    task automatic poke_registers();
        repeat ($urandom_range(2, 5))
        begin
            if ($urandom_range(0, 1))
                bus_rd(pick_addr());
            else
                bus_wr(pick_addr(), pick_word());
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4))
            send(make_item(2'($urandom_range(0, 3)),
                           $urandom_range(0, 1) ? $urandom : pick_addr(),
                           pick_word(), $urandom), 1'b0, '0);
    endtask

    // output side: random stalls, one long hold-off on request
    initial
    begin
        result_t got, want;
        int      stall_left;
        m_tready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.kind = m_tuser;
                got.rd = m_tdata[31:0];
                got.addr = m_tdata[63:32];
                got.wd = m_tdata[95:64];
                got.is_last = m_tlast;
                if (engine_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result kind %0d read %h ", $realtime,
                                 got.kind, got.rd, "addr %h wdata %h last %0d",
                                 got.addr, got.wd, got.is_last);
                end
                else
                begin
                    want = engine_replies.pop_front();
                    checked++;
                    if (got.kind !== want.kind || got.rd !== want.rd || got.addr !== want.addr
                        || got.wd !== want.wd || got.is_last !== want.is_last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch (exp/got) kind %0d/%0d read %h/%h ",
                                     $realtime, want.kind, got.kind, want.rd, got.rd,
                                     "addr %h/%h wdata %h/%h last %0d/%0d",
                                     want.addr, got.addr, want.wd, got.wd,
                                     want.is_last, got.is_last);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                holds++;
                stall_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog: cycles without any transaction on either side
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL register_mapped_dma_prbs_engine_core");
        $finish;
    end

    initial
    begin
        int unsigned next_drain;
        bit          hold_sent;
        int          pick;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_BUS_READ;
        quiet = 1'b0;
        hold_request = 1'b0;
        hold_sent = 1'b0;
        next_drain = 500;
        src_reg = '0;
        dst_reg = '0;
        len_reg = '0;
        word_idx = '0;
        seed_reg = 32'h1;
        busy = 1'b0;
        done_f = 1'b0;
        err_f = 1'b0;
        to_ext = 1'b0;
        for (int i = 0; i < LOCAL_WORDS; i++)
            local_mem[i] = '0;

        plan.push_back(fixed_row(OP_BUS_READ,  REG_STAT, 32'h0, KIND_READ, 32'h0));
        plan.push_back(fixed_row(OP_BUS_READ,  REG_SEED + ALIAS_LOW, 32'h0, KIND_READ, 32'h1));
        plan.push_back(fixed_row(OP_BUS_WRITE, REG_SEED, 32'h0, KIND_WACK, 32'h0));
        plan.push_back(fixed_row(OP_BUS_READ,  REG_SEED, 32'h0, KIND_READ, 32'h1));
        // zero length
        plan.push_back(fixed_row(OP_BUS_WRITE, REG_CTRL + ALIAS_LOW, CTL_GO, KIND_WACK, 32'h0));
        plan.push_back(fixed_row(OP_BUS_READ,  REG_STAT, 32'h0, KIND_READ,
                                 STAT_DONE | STAT_ERROR));
        // length above memory size
        plan.push_back(model_row(OP_BUS_WRITE, REG_LEN + ALIAS_LOW, LOCAL_WORDS + 1, 32'h0));
        plan.push_back(fixed_row(OP_BUS_WRITE, REG_CTRL, CTL_GO, KIND_WACK, 32'h0));
        // window sum that wraps in 32 bits
        plan.push_back(model_row(OP_BUS_WRITE, REG_DST, 32'hFFFF_FFFF, 32'h0));
        plan.push_back(model_row(OP_BUS_WRITE, REG_LEN, 32'h2, 32'h0));
        plan.push_back(fixed_row(OP_BUS_WRITE, REG_CTRL, CTL_GO, KIND_WACK, 32'h0));
        // PRBS fill with every control bit set
        plan.push_back(model_row(OP_BUS_WRITE, REG_SEED, 32'hFFFF_FFFF, 32'h0));
        plan.push_back(model_row(OP_BUS_WRITE, REG_CTRL, 32'hFFFF_FFFF, 32'h0));
        plan.push_back(model_row(OP_BUS_READ,  MEM_BASE + 4 * LOCAL_WORDS - 1, 32'h0, 32'h0));
        plan.push_back(fixed_row(OP_BUS_READ,  MEM_BASE + 4 * LOCAL_WORDS, 32'h0,
                                 KIND_READ, 32'h0));
        // external to local into the top two words
        plan.push_back(model_row(OP_BUS_WRITE, REG_DST, LOCAL_WORDS - 2, 32'h0));
        plan.push_back(model_row(OP_BUS_WRITE, REG_SRC, 32'hFFFF_FFFC, 32'h0));
        plan.push_back(model_row(OP_BUS_WRITE, REG_CTRL, CTL_GO, 32'h0));
        plan.push_back(fixed_row(OP_DMA_WACK,  32'h0, 32'h0, KIND_IGNORED, 32'h0));
        plan.push_back(model_row(OP_DMA_RDATA, 32'h0, 32'h0, 32'hFFFF_FFFF));
        plan.push_back(fixed_row(OP_BUS_WRITE, REG_CTRL, CTL_GO, KIND_WACK, 32'h0));
        // local index pushed out of range, last word dropped
        plan.push_back(model_row(OP_BUS_WRITE, REG_DST, 32'h8000_0000, 32'h0));
        plan.push_back(model_row(OP_DMA_RDATA, 32'h0, 32'h0, 32'h0));
        plan.push_back(fixed_row(OP_DMA_RDATA, 32'h0, 32'h0, KIND_IGNORED, 32'h0));
        // local to external from the top word
        plan.push_back(model_row(OP_BUS_WRITE, REG_SRC, LOCAL_WORDS - 1, 32'h0));
        plan.push_back(model_row(OP_BUS_WRITE, REG_LEN, 32'h1, 32'h0));
        plan.push_back(model_row(OP_BUS_WRITE, REG_CTRL, CTL_GO | CTL_TOEXT, 32'h0));
        plan.push_back(model_row(OP_DMA_WACK,  32'h0, 32'h0, 32'h0));
        plan.push_back(fixed_row(OP_BUS_READ,  REG_CTRL, 32'h0, KIND_READ, CTL_TOEXT));
        plan.push_back(fixed_row(OP_BUS_READ,  32'hFFFF_FFFF, 32'h0, KIND_READ, 32'h0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            send(plan[i].it, plan[i].pinned, plan[i].want);
        directed_count = sent;
        useful = 0;

        while (useful < RANDOM_ITEMS)
        begin
            quiet = (useful >= RANDOM_ITEMS - RANDOM_ITEMS / 10);
            if (!hold_sent && useful >= RANDOM_ITEMS / 3)
            begin
                hold_sent = 1'b1;
                hold_request = 1'b1;
            end
            if (useful >= next_drain)
            begin
                wait_drained();
                next_drain += 500;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
                run_transfer();
            else if (pick < 72)
                poke_registers();
            else if (pick < 82)
                send_noise();
            else if (pick < 92)
                reject_start();
            else
                run_fill();
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (engine_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input transactions (%0d directed), %0d results checked.",
                 sent, directed_count, checked);
        $display("Engine saw %0d DMA starts, %0d PRBS fills, %0d rejected starts, ",
                 dma_starts, fills, rejects, "%0d stray responses, %0d long stalls, ",
                 strays, holds, "%0d drain pauses.", pauses);
        if (mismatches == 0 && engine_replies.size() == 0)
            $display("PASS register_mapped_dma_prbs_engine_core");
        else
            $display("FAIL register_mapped_dma_prbs_engine_core");
        $finish;
    end

endmodule
